/* design/sensor_burst_average_peak_scaler_macros.svh */
// Assertion macros shared by the burst scaler front and queue modules.
// Each macro expects signals named clock and reset in the calling module.
`ifndef SENSOR_BURST_AVERAGE_PEAK_SCALER_MACROS_SVH
`define SENSOR_BURST_AVERAGE_PEAK_SCALER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define SBAPS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SBAPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/sbaps_pkg.sv */
`default_nettype none
package sbaps_pkg;

   // Channel codes
   localparam logic [2:0] CH_LOOP  = 3'd0;
   localparam logic [2:0] CH_TEMP  = 3'd1;
   localparam logic [2:0] CH_HUMID = 3'd2;
   localparam logic [2:0] CH_VOLT  = 3'd3;
   localparam logic [2:0] CH_AMP   = 3'd4;

   // Default burst lengths
   localparam int DEF_LOOP_SAMPLES  = 10;
   localparam int DEF_VOLT_SAMPLES  = 50;
   localparam int DEF_AMP_SAMPLES   = 60;
   localparam int DEF_READ_ATTEMPTS = 20;

   // Job queue depth (power of two)
   localparam int QUEUE_DEPTH = 4;

   // Field widths
   localparam int SAMPLE_W = 10;
   localparam int VALUE_W  = 18;
   localparam int SUM_W    = 16;
   localparam int COUNT_W  = 7;
   localparam int X_W      = 17;

   // Scaling unit: value = floor(x * K / D)
   localparam int K_W      = 20;
   localparam int D_W      = 16;
   localparam int R_W      = 25;
   localparam int RECIP_SH = 17;
   localparam int EST_W    = X_W + R_W;
   localparam int EXACT_W  = X_W + K_W;
   localparam int QD_W     = VALUE_W + D_W;

   localparam logic [K_W-1:0] K_LOOP = K_W'(20 * 256);
   localparam logic [K_W-1:0] K_VOLT = K_W'(1000 * 256);
   localparam logic [K_W-1:0] K_AMP  = K_W'(3300 * 256);
   localparam logic [D_W-1:0] D_AMP  = D_W'(1023 * 37);

   // Peak midpoint, in units of half an ADC code
   localparam logic [SAMPLE_W:0] PEAK_MID = 11'd1013;

   // One finished burst handed from front to back
   typedef struct packed {
      logic [2:0]         channel;
      logic               scaled;   // data is x for the scaling unit
      logic               updated;
      logic [VALUE_W-1:0] data;     // x when scaled, else the final value
   } job_type;

endpackage
`default_nettype wire

/* design/sbaps_front.sv */
`default_nettype none
`include "sensor_burst_average_peak_scaler_macros.svh"
module sbaps_front #(
   parameter int LOOP_SAMPLES  = sbaps_pkg::DEF_LOOP_SAMPLES,
   parameter int VOLT_SAMPLES  = sbaps_pkg::DEF_VOLT_SAMPLES,
   parameter int AMP_SAMPLES   = sbaps_pkg::DEF_AMP_SAMPLES,
   parameter int READ_ATTEMPTS = sbaps_pkg::DEF_READ_ATTEMPTS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic                             first,
   input  wire logic [2:0]                       channel,
   input  wire logic [sbaps_pkg::SAMPLE_W-1:0]   sample,
   input  wire logic                             read_ok,
   output logic                                  push,
   output sbaps_pkg::job_type                    job
);
   import sbaps_pkg::*;

   localparam logic [COUNT_W-1:0] LOOP_N  = COUNT_W'(LOOP_SAMPLES);
   localparam logic [COUNT_W-1:0] VOLT_N  = COUNT_W'(VOLT_SAMPLES);
   localparam logic [COUNT_W-1:0] AMP_N   = COUNT_W'(AMP_SAMPLES);
   localparam logic [COUNT_W-1:0] TRIES_N = COUNT_W'(READ_ATTEMPTS);
   localparam logic [X_W-1:0] LOOP_BIAS   = X_W'(5 * LOOP_SAMPLES);
   localparam logic [X_W-1:0] VOLT_BIAS   = X_W'(5 * VOLT_SAMPLES);

   logic                 busy_ff, busy_in;
   logic [2:0]           chan_ff, chan_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SAMPLE_W-1:0]  peak_ff, peak_in;
   logic [COUNT_W-2:0]   count_ff, count_in;
   logic [1:0]           good_ff, good_in;

   logic                 busy_eff;
   logic [2:0]           chan_eff;
   logic [SUM_W-1:0]     sum_eff, sum_add;
   logic [SAMPLE_W-1:0]  peak_eff, peak_new;
   logic [COUNT_W-2:0]   count_eff;
   logic [1:0]           good_eff, good_new;
   logic [COUNT_W-1:0]   next_count;
   logic [SAMPLE_W:0]    twice;
   logic [SAMPLE_W:0]    mid_gap;
   logic                 done;

   // Open a burst on a first item, else continue the current one
   always_comb begin
      busy_eff   = first ? (channel <= CH_AMP) : busy_ff;
      chan_eff   = first ? channel : chan_ff;
      sum_eff    = first ? '0 : sum_ff;
      peak_eff   = first ? '0 : peak_ff;
      count_eff  = first ? '0 : count_ff;
      good_eff   = first ? '0 : good_ff;
      next_count = {1'b0, count_eff} + COUNT_W'(1);
      sum_add    = sum_eff + SUM_W'(sample);
      peak_new   = (sample > peak_eff) ? sample : peak_eff;
      twice      = {peak_new, 1'b0};
      mid_gap    = (twice >= PEAK_MID) ? (twice - PEAK_MID) : (PEAK_MID - twice);
   end

   // Accumulate per channel and build the job when the burst ends
   always_comb begin
      sum_in       = sum_eff;
      peak_in      = peak_eff;
      good_in      = good_eff;
      good_new     = good_eff;
      done         = 1'b0;
      job.channel  = chan_eff;
      job.scaled   = 1'b1;
      job.updated  = 1'b1;
      job.data     = '0;
      case (chan_eff)
         CH_LOOP: begin
            sum_in   = sum_add;
            done     = next_count >= LOOP_N;
            job.data = VALUE_W'({1'b0, sum_add} + LOOP_BIAS);
         end
         CH_VOLT: begin
            sum_in   = sum_add;
            done     = next_count >= VOLT_N;
            job.data = VALUE_W'({1'b0, sum_add} + VOLT_BIAS);
         end
         CH_AMP: begin
            peak_in  = peak_new;
            done     = next_count >= AMP_N;
            job.data = VALUE_W'(mid_gap);
         end
         default: begin
            if (read_ok) begin
               sum_in   = sum_add;
               good_new = good_eff + 2'd1;
            end
            good_in    = good_new;
            job.scaled = 1'b0;
            if (good_new >= 2'd2) begin
               done     = 1'b1;
               job.data = {sum_in[VALUE_W-8:0], 7'b0};
            end else if (next_count >= TRIES_N) begin
               done = 1'b1;
               if (good_new == 2'd1) begin
                  job.data = {sum_in[VALUE_W-9:0], 8'b0};
               end else begin
                  job.updated = 1'b0;
               end
            end
         end
      endcase
      busy_in  = busy_eff && !done;
      chan_in  = chan_eff;
      count_in = next_count[COUNT_W-2:0];
      push     = accept && busy_eff && done;
   end

   // Hold burst state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff  <= chan_in;
         sum_ff   <= sum_in;
         peak_ff  <= peak_in;
         count_ff <= count_in;
         good_ff  <= good_in;
      end
   end

   `SBAPS_ASSERT_SAME(a_push_on_accept, push, accept, "job pushed without an input transfer")
   `SBAPS_ASSERT_SAME(a_no_push_idle, accept && !first && !busy_ff, !push, "job from idle block")
   `SBAPS_ASSERT_NEXT(a_done_idles, push && !(busy_eff && !done), !busy_ff, "busy after burst end")

endmodule
`default_nettype wire

/* design/sbaps_queue.sv */
`default_nettype none
`include "sensor_burst_average_peak_scaler_macros.svh"
module sbaps_queue #(
   parameter int DEPTH = sbaps_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sbaps_pkg::job_type push_job,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output sbaps_pkg::job_type      pop_job
);
   import sbaps_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type              mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
      full    = count_ff == CNT_W'(DEPTH);
      empty   = count_ff == '0;
      pop_job = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `SBAPS_ASSERT_SAME(a_no_overflow, push, !full, "push into full queue")
   `SBAPS_ASSERT_SAME(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule
`default_nettype wire

/* design/sbaps_back.sv */
`default_nettype none
module sbaps_back #(
   parameter int LOOP_SAMPLES = sbaps_pkg::DEF_LOOP_SAMPLES,
   parameter int VOLT_SAMPLES = sbaps_pkg::DEF_VOLT_SAMPLES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           empty,
   input  wire sbaps_pkg::job_type             pop_job,
   output logic                                pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [2:0]                          rsp_channel,
   output logic [sbaps_pkg::VALUE_W-1:0]       rsp_value,
   output logic                                rsp_updated
);
   import sbaps_pkg::*;

   localparam logic [D_W-1:0] D_LOOP = D_W'(1023 * LOOP_SAMPLES);
   localparam logic [D_W-1:0] D_VOLT = D_W'(1023 * VOLT_SAMPLES);
   localparam logic [63:0] R_LOOP_WIDE = (64'(K_LOOP) << RECIP_SH) / 64'(D_LOOP);
   localparam logic [63:0] R_VOLT_WIDE = (64'(K_VOLT) << RECIP_SH) / 64'(D_VOLT);
   localparam logic [63:0] R_AMP_WIDE  = (64'(K_AMP) << RECIP_SH) / 64'(D_AMP);
   localparam logic [R_W-1:0] R_LOOP = R_LOOP_WIDE[R_W-1:0];
   localparam logic [R_W-1:0] R_VOLT = R_VOLT_WIDE[R_W-1:0];
   localparam logic [R_W-1:0] R_AMP  = R_AMP_WIDE[R_W-1:0];

   logic                 adv;
   logic [K_W-1:0]       k_sel;
   logic [D_W-1:0]       d_sel;
   logic [R_W-1:0]       r_sel;
   logic [X_W-1:0]       x;

   logic                 s1_valid_ff;
   job_type              s1_job_ff;
   logic [EST_W-1:0]     s1_est_ff;
   logic [EXACT_W-1:0]   s1_exact_ff;
   logic [D_W-1:0]       s1_d_ff;

   logic                 s2_valid_ff;
   job_type              s2_job_ff;
   logic [VALUE_W-1:0]   s2_q_ff;
   logic [EXACT_W-1:0]   s2_exact_ff;
   logic [D_W-1:0]       s2_d_ff;

   logic                 s3_valid_ff;
   job_type              s3_job_ff;
   logic [VALUE_W-1:0]   s3_q_ff;
   logic [QD_W-1:0]      s3_qd_ff;
   logic [EXACT_W-1:0]   s3_exact_ff;
   logic [D_W-1:0]       s3_d_ff;

   logic [EXACT_W-1:0]   remainder;
   logic [VALUE_W-1:0]   value_in;

   logic                 out_valid_ff;
   logic [2:0]           out_channel_ff;
   logic [VALUE_W-1:0]   out_value_ff;
   logic                 out_updated_ff;

   // Advance the whole pipeline unless the output register is held
   always_comb begin
      adv = !out_valid_ff || rsp_ready;
      pop = adv && !empty;
      x   = pop_job.data[X_W-1:0];
      case (pop_job.channel)
         CH_LOOP: begin
            k_sel = K_LOOP;
            d_sel = D_LOOP;
            r_sel = R_LOOP;
         end
         CH_VOLT: begin
            k_sel = K_VOLT;
            d_sel = D_VOLT;
            r_sel = R_VOLT;
         end
         default: begin
            k_sel = K_AMP;
            d_sel = D_AMP;
            r_sel = R_AMP;
         end
      endcase
   end

   // Correct the quotient estimate by one step
   always_comb begin
      remainder = s3_exact_ff - EXACT_W'(s3_qd_ff);
      if (!s3_job_ff.scaled) begin
         value_in = s3_job_ff.data;
      end else if (remainder >= EXACT_W'(s3_d_ff)) begin
         value_in = s3_q_ff + VALUE_W'(1);
      end else begin
         value_in = s3_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // Reciprocal estimate, exact product, quotient times divisor
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_job_ff      <= pop_job;
         s1_est_ff      <= EST_W'(x) * EST_W'(r_sel);
         s1_exact_ff    <= EXACT_W'(x) * EXACT_W'(k_sel);
         s1_d_ff        <= d_sel;
         s2_job_ff      <= s1_job_ff;
         s2_q_ff        <= s1_est_ff[RECIP_SH+VALUE_W-1:RECIP_SH];
         s2_exact_ff    <= s1_exact_ff;
         s2_d_ff        <= s1_d_ff;
         s3_job_ff      <= s2_job_ff;
         s3_q_ff        <= s2_q_ff;
         s3_qd_ff       <= QD_W'(s2_q_ff) * QD_W'(s2_d_ff);
         s3_exact_ff    <= s2_exact_ff;
         s3_d_ff        <= s2_d_ff;
         out_channel_ff <= s3_job_ff.channel;
         out_value_ff   <= value_in;
         out_updated_ff <= s3_job_ff.updated;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_channel = out_channel_ff;
   assign rsp_value   = out_value_ff;
   assign rsp_updated = out_updated_ff;

endmodule
`default_nettype wire

/* design/sensor_burst_average_peak_scaler.sv */
// Sensor burst scaler: each input transfer is one sample of a burst; a transfer with
// first set opens a burst for its channel (0 loop current, 1 temperature, 2 humidity,
// 3 voltage, 4 peak current) and is its first sample. One result transfer follows the
// sample that ends a burst, carrying the value times 256 (truncated) and the updated
// flag. The block takes one sample per clock cycle while req_tready is high. The job of
// a closing sample passes through the job queue, the three-stage reciprocal-multiply
// scaling pipeline and the output register. Finished bursts wait in a four-entry job
// queue, and req_tready drops only while that queue is full.
`default_nettype none
module sensor_burst_average_peak_scaler #(
   parameter int LOOP_SAMPLES  = sbaps_pkg::DEF_LOOP_SAMPLES,
   parameter int VOLT_SAMPLES  = sbaps_pkg::DEF_VOLT_SAMPLES,
   parameter int AMP_SAMPLES   = sbaps_pkg::DEF_AMP_SAMPLES,
   parameter int READ_ATTEMPTS = sbaps_pkg::DEF_READ_ATTEMPTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // sample[9:0]
   input  wire logic [4:0]  req_tuser,    // first[0], channel[3:1], read_ok[4]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,    // value[17:0]
   output logic [3:0]       rsp_tuser     // out_channel[2:0], updated[3]
);
   import sbaps_pkg::*;

   logic               accept;
   logic               push;
   logic               pop;
   logic               full;
   logic               empty;
   job_type            push_job;
   job_type            pop_job;
   logic [2:0]         rsp_channel;
   logic [VALUE_W-1:0] rsp_value;
   logic               rsp_updated;

   // Take a transfer whenever the job queue has room
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   sbaps_front #(
      .LOOP_SAMPLES  (LOOP_SAMPLES),
      .VOLT_SAMPLES  (VOLT_SAMPLES),
      .AMP_SAMPLES   (AMP_SAMPLES),
      .READ_ATTEMPTS (READ_ATTEMPTS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .first   (req_tuser[0]),
      .channel (req_tuser[3:1]),
      .sample  (req_tdata[SAMPLE_W-1:0]),
      .read_ok (req_tuser[4]),
      .push    (push),
      .job     (push_job)
   );

   sbaps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .pop_job  (pop_job)
   );

   sbaps_back #(
      .LOOP_SAMPLES (LOOP_SAMPLES),
      .VOLT_SAMPLES (VOLT_SAMPLES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (empty),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_channel (rsp_channel),
      .rsp_value   (rsp_value),
      .rsp_updated (rsp_updated)
   );

   // Pack the result transfer
   assign rsp_tdata = {6'b0, rsp_value};
   assign rsp_tuser = {rsp_updated, rsp_channel};

endmodule
`default_nettype wire

/* test/sensor_burst_average_peak_scaler_tb.sv */
module sensor_burst_average_peak_scaler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sbaps_pkg::*;

   // Channel codes that no sensor uses
   localparam logic [2:0] CH_FIRST_UNUSED = CH_AMP + 3'd1;
   localparam logic [2:0] CH_LAST_UNUSED  = 3'd7;

   localparam int RANDOM_ITEMS = 1600;
   localparam int SQUEEZE_CYCLES = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam longint CYCLE_LIMIT = 1000000;

   // One converted reading as it leaves the block
   typedef struct packed {
      logic [2:0]  channel;
      logic [17:0] value;
      logic        updated;
   } reading_type;

   // One row of the directed plan: an item sent reps times in a row
   typedef struct packed {
      logic        first;
      logic [2:0]  channel;
      logic [9:0]  sample;
      logic        read_ok;
      logic [6:0]  reps;
      logic        rnd;          // draw sample and read_ok at random
      logic        typed;        // last repetition closes a burst with a known reading
      logic [2:0]  exp_channel;
      logic [17:0] exp_value;
      logic        exp_updated;
   } plan_row_type;

   localparam int PLAN_ROWS = 34;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // sample[9:0]
   logic [4:0]  req_tuser = '0;    // first[0], channel[3:1], read_ok[4]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // value[17:0]
   logic [3:0]  rsp_tuser;         // out_channel[2:0], updated[3]

   // Burst tracker state
   logic [2:0]  burst_ch;
   logic        burst_open;
   logic [15:0] acc_sum;
   logic [9:0]  acc_peak;
   logic [5:0]  attempts;
   logic [1:0]  good_count;

   reading_type expected_readings[$];
   int       mismatch_count;
   int       live_items;
   longint   cycle_count;
   int       send_calm;
   int       recv_calm;
   bit       squeeze_pending;

   plan_row_type plan [0:PLAN_ROWS-1] = '{
      // nothing open yet: ignored
      '{1'b0, CH_LOOP, 10'd5, 1'b0, 7'd2, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      // loop channel, all codes full scale, then all zero
      '{1'b1, CH_LOOP, 10'd1023, 1'b1, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_LOOP, 10'd1023, 1'b0, 7'd9, 1'b0, 1'b1, CH_LOOP, 18'd5145, 1'b1},
      '{1'b1, CH_LOOP, 10'd0, 1'b0, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_LOOP, 10'd0, 1'b1, 7'd9, 1'b0, 1'b1, CH_LOOP, 18'd25, 1'b1},
      // unknown channel leaves the block idle
      '{1'b1, CH_LAST_UNUSED, 10'd0, 1'b0, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_LOOP, 10'd100, 1'b0, 7'd3, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      // unknown channel in the middle of a burst drops it
      '{1'b1, CH_VOLT, 10'd500, 1'b1, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_VOLT, 10'd300, 1'b0, 7'd4, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b1, CH_FIRST_UNUSED, 10'd0, 1'b0, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_VOLT, 10'd300, 1'b0, 7'd2, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      // voltage channel extremes
      '{1'b1, CH_VOLT, 10'd1023, 1'b1, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_VOLT, 10'd1023, 1'b1, 7'd49, 1'b0, 1'b1, CH_VOLT, 18'd257251, 1'b1},
      '{1'b1, CH_VOLT, 10'd0, 1'b0, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_VOLT, 10'd0, 1'b0, 7'd49, 1'b0, 1'b1, CH_VOLT, 18'd1251, 1'b1},
      // peak current: peak on the first sample, all zero, just below midpoint
      '{1'b1, CH_AMP, 10'd1023, 1'b1, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_AMP, 10'd0, 1'b1, 7'd59, 1'b0, 1'b1, CH_AMP, 18'd23055, 1'b1},
      '{1'b1, CH_AMP, 10'd0, 1'b0, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_AMP, 10'd0, 1'b0, 7'd59, 1'b0, 1'b1, CH_AMP, 18'd22609, 1'b1},
      '{1'b1, CH_AMP, 10'd506, 1'b0, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_AMP, 10'd506, 1'b1, 7'd59, 1'b0, 1'b1, CH_AMP, 18'd22, 1'b1},
      // temperature: every attempt fails
      '{1'b1, CH_TEMP, 10'd1023, 1'b0, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_TEMP, 10'd1023, 1'b0, 7'd19, 1'b0, 1'b1, CH_TEMP, 18'd0, 1'b0},
      // humidity: two good reads right away
      '{1'b1, CH_HUMID, 10'd1023, 1'b1, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_HUMID, 10'd1023, 1'b1, 7'd1, 1'b0, 1'b1, CH_HUMID, 18'd261888, 1'b1},
      // temperature: a single good read
      '{1'b1, CH_TEMP, 10'd1023, 1'b1, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_TEMP, 10'd555, 1'b0, 7'd19, 1'b0, 1'b1, CH_TEMP, 18'd261888, 1'b1},
      // humidity burst cut short by a new temperature burst
      '{1'b1, CH_HUMID, 10'd7, 1'b0, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_HUMID, 10'd300, 1'b1, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b1, CH_TEMP, 10'd12, 1'b1, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_TEMP, 10'd0, 1'b0, 7'd1, 1'b1, 1'b0, CH_LOOP, 18'd0, 1'b0},
      // loop channel with random codes
      '{1'b1, CH_LOOP, 10'd0, 1'b0, 7'd1, 1'b1, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b0, CH_LOOP, 10'd0, 1'b0, 7'd9, 1'b1, 1'b0, CH_LOOP, 18'd0, 1'b0},
      '{1'b1, CH_LAST_UNUSED, 10'd1023, 1'b1, 7'd1, 1'b0, 1'b0, CH_LOOP, 18'd0, 1'b0}
   };

   sensor_burst_average_peak_scaler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle length: mostly none or short, a few long, and calm stretches with none
   function automatic int idle_len(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Average of n codes as a fixed-point value: 256*k*(sum+5n)/(1023n)
   function automatic logic [17:0] average_to_fixed(input logic [15:0] sum, input int n,
                                                    input int k);
      longint unsigned num;
      num = (64'(sum) + 64'(5 * n)) * 64'(k) * 64'd256;
      return 18'(num / 64'(1023 * n));
   endfunction

   // Advance the burst tracker by one sample; return 1 when a burst closes
   function automatic bit advance_burst(input logic first, input logic [2:0] ch,
                                        input logic [9:0] smp, input logic ok,
                                        output reading_type rd);
      logic [6:0]      nxt;
      bit              done;
      int              mid_gap;
      longint unsigned num;
      done = 1'b0;
      rd = '{channel: burst_ch, value: 18'd0, updated: 1'b1};
      if (first) begin
         acc_sum = '0;
         acc_peak = '0;
         attempts = '0;
         good_count = '0;
         if (ch > CH_AMP) begin
            burst_open = 1'b0;
            return 1'b0;
         end
         burst_ch = ch;
         burst_open = 1'b1;
      end
      if (!burst_open) return 1'b0;
      rd.channel = burst_ch;

      nxt = {1'b0, attempts} + 7'd1;
      case (burst_ch)
         CH_LOOP: begin
            acc_sum = acc_sum + 16'(smp);
            if (nxt >= DEF_LOOP_SAMPLES) begin
               rd.value = average_to_fixed(acc_sum, DEF_LOOP_SAMPLES, 20);
               done = 1'b1;
            end
         end
         CH_VOLT: begin
            acc_sum = acc_sum + 16'(smp);
            if (nxt >= DEF_VOLT_SAMPLES) begin
               rd.value = average_to_fixed(acc_sum, DEF_VOLT_SAMPLES, 1000);
               done = 1'b1;
            end
         end
         CH_AMP: begin
            if (smp > acc_peak) acc_peak = smp;
            if (nxt >= DEF_AMP_SAMPLES) begin
               // distance from the midpoint in half codes, 3300 mV over 1023 codes, 18.5 mV/A
               mid_gap = 2 * int'(acc_peak) - 1013;
               if (mid_gap < 0) mid_gap = -mid_gap;
               num = 64'(mid_gap) * 64'd3300 * 64'd256;
               rd.value = 18'(num / 64'(1023 * 37));
               done = 1'b1;
            end
         end
         default: begin
            if (ok) begin
               acc_sum = acc_sum + 16'(smp);
               good_count = good_count + 2'd1;
            end
            if (good_count >= 2'd2) begin
               rd.value = 18'(32'(acc_sum) * 128);
               done = 1'b1;
            end else if (nxt >= DEF_READ_ATTEMPTS) begin
               if (good_count == 2'd1) begin
                  rd.value = 18'(32'(acc_sum) * 256);
               end else begin
                  rd.updated = 1'b0;
               end
               done = 1'b1;
            end
         end
      endcase
      attempts = nxt[5:0];
      if (done) burst_open = 1'b0;
      return done;
   endfunction

   // Offer one sample, wait for the transfer, and record what it should produce
   task automatic send_sample(input logic first, input logic [2:0] ch, input logic [9:0] smp,
                              input logic ok, input bit typed, input reading_type typed_rd);
      int          gap;
      bit          got;
      reading_type rd;
      gap = idle_len(send_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, smp};
      req_tuser <= {ok, ch, first};
      do @(posedge clock); while (!req_tready);
      if ((first && ch <= CH_AMP) || (!first && burst_open)) live_items++;
      got = advance_burst(first, ch, smp, ok, rd);
      if (typed) expected_readings.push_back(typed_rd);
      else if (got) expected_readings.push_back(rd);
   endtask

   task automatic note_mismatch(input string what, input longint want, input longint seen);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s: expected %0d, got %0d", what, want, seen);
   endtask

   // Stimulus: directed plan, then random bursts
   initial begin
      int          kind;
      int          len;
      int          full;
      int          style;
      int          ok_pct;
      bit          second_squeeze;
      logic [2:0]  ch;
      logic [9:0]  smp;
      logic        ok;
      reading_type typed_rd;

      burst_ch = '0;
      burst_open = 1'b0;
      acc_sum = '0;
      acc_peak = '0;
      attempts = '0;
      good_count = '0;
      second_squeeze = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed plan
      for (int i = 0; i < PLAN_ROWS; i++) begin
         typed_rd = '{channel: plan[i].exp_channel, value: plan[i].exp_value,
                      updated: plan[i].exp_updated};
         for (int r = 0; r < int'(plan[i].reps); r++) begin
            smp = plan[i].rnd ? 10'($urandom_range(0, 1023)) : plan[i].sample;
            ok = plan[i].rnd ? 1'($urandom_range(0, 1)) : plan[i].read_ok;
            send_sample(plan[i].first, plan[i].channel, smp, ok,
                        plan[i].typed && (r == int'(plan[i].reps) - 1), typed_rd);
         end
      end

      // Random bursts, with the receiver held off at the start and halfway
      squeeze_pending = 1'b1;
      live_items = 0;
      while (live_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 6) begin
            // stray samples
            repeat ($urandom_range(1, 3))
               send_sample(1'b0, 3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)),
                           1'($urandom_range(0, 1)), 1'b0, typed_rd);
         end else begin
            if (kind < 10) ch = 3'($urandom_range(CH_FIRST_UNUSED, CH_LAST_UNUSED));
            else ch = 3'($urandom_range(CH_LOOP, CH_AMP));
            case (ch)
               CH_LOOP: full = DEF_LOOP_SAMPLES;
               CH_VOLT: full = DEF_VOLT_SAMPLES;
               CH_AMP:  full = DEF_AMP_SAMPLES;
               CH_TEMP, CH_HUMID: full = DEF_READ_ATTEMPTS;
               default: full = 4;
            endcase
            // some bursts stop early and get restarted by the next one
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, full - 1) : full;
            style = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
               0: ok_pct = 0;
               1: ok_pct = 15;
               2: ok_pct = 50;
               default: ok_pct = 90;
            endcase
            for (int k = 0; k < len; k++) begin
               if (k > 0 && ch <= CH_AMP && !burst_open) break;
               case (style)
                  0: smp = 10'($urandom_range(0, 1023));
                  1: smp = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                  2: smp = 10'($urandom_range(500, 515));
                  default: smp = 10'($urandom_range(960, 1023));
               endcase
               send_sample(k == 0, (k == 0) ? ch : 3'($urandom_range(0, 7)), smp,
                           $urandom_range(0, 99) < ok_pct, 1'b0, typed_rd);
            end
         end
         if (live_items >= RANDOM_ITEMS / 2 && !second_squeeze) begin
            second_squeeze = 1'b1;
            squeeze_pending = 1'b1;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain, then let the pipeline settle
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Receiver: random stalls, plus long hold-offs on request
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (squeeze_pending) begin
            squeeze_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(negedge clock);
         end
         stall = idle_len(recv_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // Check each result transfer against the oldest expected reading
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            note_mismatch("unexpected result value", -1, rsp_tdata[17:0]);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_tuser[2:0] !== want.channel)
               note_mismatch("out_channel", want.channel, rsp_tuser[2:0]);
            if (rsp_tdata[17:0] !== want.value)
               note_mismatch("value", want.value, rsp_tdata[17:0]);
            if (rsp_tuser[3] !== want.updated)
               note_mismatch("updated", want.updated, rsp_tuser[3]);
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      cycle_count = 0;
      mismatch_count = 0;
      live_items = 0;
      send_calm = 0;
      recv_calm = 0;
      squeeze_pending = 1'b0;
   end

endmodule
